### hdl/lspc_pkg.sv
`timescale 1ns / 1ps

package lspc_pkg;

  // Scan and field geometry
  localparam int MAX_BEAMS     = 4096;
  localparam int INDEX_BITS    = 12;
  localparam int DISTANCE_BITS = 20;
  localparam int COORD_BITS    = DISTANCE_BITS + 1;
  localparam int INTEN_BITS    = 16;
  localparam int ANGLE_BITS    = 32;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_START_ANGLE       = 3'd0,
    CFG_ANGLE_STEP        = 3'd1,
    CFG_MIN_DISTANCE      = 3'd2,
    CFG_MAX_DISTANCE      = 3'd3,
    CFG_INTENSITY_PRESENT = 3'd4
  } cfg_reg_t;

  // Rotation datapath, Q2.30 plus guard bits
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam int MAG_W        = 32;
  localparam int PROD_W       = MAG_W + DISTANCE_BITS;
  localparam int ROUND_SHIFT  = 30;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] HALF_TURN       = 34'sd2147483648;
  localparam logic signed [CORDIC_W-1:0] QUARTER_TURN    = 34'sd1073741824;

  // atan(2^-i) in binary angle units, rounded down
  localparam logic [31:0] ATAN_UNITS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

endpackage

### hdl/lspc_beam_if.sv
`timescale 1ns / 1ps

interface lspc_beam_if;
  import lspc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [INDEX_BITS-1:0]    beam_index;
  logic                     echo_valid;
  logic [DISTANCE_BITS-1:0] distance;
  logic [INTEN_BITS-1:0]    beam_intensity;

  modport source (output valid, beam_index, echo_valid, distance, beam_intensity,
                  input ready);
  modport sink   (input valid, beam_index, echo_valid, distance, beam_intensity,
                  output ready);
endinterface

### hdl/lspc_point_if.sv
`timescale 1ns / 1ps

interface lspc_point_if;
  import lspc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [INTEN_BITS-1:0]        point_intensity;

  modport source (output valid, point_x, point_y, point_intensity, input ready);
  modport sink   (input valid, point_x, point_y, point_intensity, output ready);
endinterface

### hdl/lspc_cfg_if.sv
`timescale 1ns / 1ps

interface lspc_cfg_if;
  import lspc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/laser_scan_polar_to_cartesian_top.sv
`timescale 1ns / 1ps

// Laser scan polar-to-Cartesian converter. One beam item per cycle enters on
// the beam channel while the output is not stalled; a beam with an echo and a
// distance inside [min_distance, max_distance] leaves as one point item (x, y
// in 1/4096 m, plus intensity, zeroed unless intensity_present is set); any
// other beam is dropped. Throughput is one item per clock while the output is
// not stalled. The pipe has one stage for the index*step multiply, one for
// the angle add, one for the half-turn fold, thirty CORDIC rotation stages
// (one iteration each), one for the distance multiplies and one output
// register for rounding and clamping. The whole pipe moves as one while the
// output register is empty or being taken; a stalled output holds every
// stage, so beam.ready is low only while a point item waits untaken.
// Configuration writes are always taken (cfg.ready is high) and
// must only be issued while the pipe is empty.

module laser_scan_polar_to_cartesian_top (
  input  logic clk,
  input  logic rst,
  lspc_beam_if.sink    beam,
  lspc_point_if.source point,
  lspc_cfg_if.sink     cfg
);
  import lspc_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ANGLE_BITS-1:0]    start_angle;
  logic [ANGLE_BITS-1:0]    angle_step;
  logic [DISTANCE_BITS-1:0] min_distance;
  logic [DISTANCE_BITS-1:0] max_distance;
  logic                     intensity_present;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle       <= '0;
      angle_step        <= '0;
      min_distance      <= '0;
      max_distance      <= '1;
      intensity_present <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        CFG_START_ANGLE:       start_angle       <= cfg.data[ANGLE_BITS-1:0];
        CFG_ANGLE_STEP:        angle_step        <= cfg.data[ANGLE_BITS-1:0];
        CFG_MIN_DISTANCE:      min_distance      <= cfg.data[DISTANCE_BITS-1:0];
        CFG_MAX_DISTANCE:      max_distance      <= cfg.data[DISTANCE_BITS-1:0];
        CFG_INTENSITY_PRESENT: intensity_present <= cfg.data[0];
        default: ;  // unmapped index: write ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipe advance: everything moves unless the output item is stuck
  // ---------------------------------------------------------------------
  logic adv;
  assign adv        = !point.valid || point.ready;
  assign beam.ready = adv;

  // ---------------------------------------------------------------------
  // Entry filter: no echo, out of range or index past the scan -> bubble
  // ---------------------------------------------------------------------
  logic                          keep;
  logic [INDEX_BITS+ANGLE_BITS-1:0] step_prod;

  assign keep = beam.valid && beam.echo_valid
             && ({1'b0, beam.beam_index} < (INDEX_BITS+1)'(MAX_BEAMS))
             && (beam.distance >= min_distance)
             && (beam.distance <= max_distance);

  assign step_prod = {{ANGLE_BITS{1'b0}}, beam.beam_index}
                   * {{INDEX_BITS{1'b0}}, angle_step};

  // Stage 1: index * step (angle wraps, low bits only)
  logic                     v1;
  logic [ANGLE_BITS-1:0]    prod1;
  logic [DISTANCE_BITS-1:0] dist1;
  logic [INTEN_BITS-1:0]    inten1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1  <= step_prod[ANGLE_BITS-1:0];
      dist1  <= beam.distance;
      inten1 <= intensity_present ? beam.beam_intensity : '0;
    end
  end

  // Stage 2: beam angle
  logic                     v2;
  logic [ANGLE_BITS-1:0]    angle2;
  logic [DISTANCE_BITS-1:0] dist2;
  logic [INTEN_BITS-1:0]    inten2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle2 <= start_angle + prod1;
      dist2  <= dist1;
      inten2 <= inten1;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: fold into [-quarter, +quarter]; a half-turn shift negates both
  // outputs, remembered in flip. Then CORDIC stages 1..30.
  // ---------------------------------------------------------------------
  logic signed [CORDIC_W-1:0] z_raw;
  logic signed [CORDIC_W-1:0] z_fold;
  logic                       flip_fold;

  assign z_raw = CORDIC_W'(signed'(angle2));

  always_comb begin
    z_fold    = z_raw;
    flip_fold = 1'b0;
    if (z_raw > QUARTER_TURN) begin
      z_fold    = z_raw - HALF_TURN;
      flip_fold = 1'b1;
    end else if (z_raw < -QUARTER_TURN) begin
      z_fold    = z_raw + HALF_TURN;
      flip_fold = 1'b1;
    end
  end

  logic                       cv     [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] cx     [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] cy     [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] cz     [CORDIC_STEPS+1];
  logic                       cflip  [CORDIC_STEPS+1];
  logic [DISTANCE_BITS-1:0]   cdist  [CORDIC_STEPS+1];
  logic [INTEN_BITS-1:0]      cinten [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0]     <= CORDIC_GAIN_Q30;
      cy[0]     <= '0;
      cz[0]     <= z_fold;
      cflip[0]  <= flip_fold;
      cdist[0]  <= dist2;
      cinten[0] <= inten2;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [CORDIC_W-1:0] at;

    assign xs = cx[i] >>> i;   // floor shift
    assign ys = cy[i] >>> i;
    assign at = CORDIC_W'(ATAN_UNITS[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (adv) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - at;
        end else begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + at;
        end
        cflip[i+1]  <= cflip[i];
        cdist[i+1]  <= cdist[i];
        cinten[i+1] <= cinten[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Multiply stage: |cos| * d and |sin| * d; sign of each coordinate is the
  // CORDIC sign xor flip (a zero term has zero product, sign irrelevant)
  // ---------------------------------------------------------------------
  logic signed [CORDIC_W-1:0] xf;
  logic signed [CORDIC_W-1:0] yf;
  logic [CORDIC_W-1:0]        xabs;
  logic [CORDIC_W-1:0]        yabs;

  assign xf   = cx[CORDIC_STEPS];
  assign yf   = cy[CORDIC_STEPS];
  assign xabs = xf[CORDIC_W-1] ? CORDIC_W'(-xf) : CORDIC_W'(xf);
  assign yabs = yf[CORDIC_W-1] ? CORDIC_W'(-yf) : CORDIC_W'(yf);

  logic                     vm;
  logic [PROD_W-1:0]        prod_x;
  logic [PROD_W-1:0]        prod_y;
  logic                     neg_x;
  logic                     neg_y;
  logic [DISTANCE_BITS-1:0] distm;
  logic [INTEN_BITS-1:0]    intenm;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (adv) begin
      vm <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_x <= {{DISTANCE_BITS{1'b0}}, xabs[MAG_W-1:0]}
              * {{MAG_W{1'b0}}, cdist[CORDIC_STEPS]};
      prod_y <= {{DISTANCE_BITS{1'b0}}, yabs[MAG_W-1:0]}
              * {{MAG_W{1'b0}}, cdist[CORDIC_STEPS]};
      neg_x  <= xf[CORDIC_W-1] ^ cflip[CORDIC_STEPS];
      neg_y  <= yf[CORDIC_W-1] ^ cflip[CORDIC_STEPS];
      distm  <= cdist[CORDIC_STEPS];
      intenm <= cinten[CORDIC_STEPS];
    end
  end

  // ---------------------------------------------------------------------
  // Output register: round half up at bit 30, clamp to d, apply sign
  // ---------------------------------------------------------------------
  localparam int RW = PROD_W + 1 - ROUND_SHIFT;

  logic [PROD_W:0]         rx_sum;
  logic [PROD_W:0]         ry_sum;
  logic [RW-1:0]           rx;
  logic [RW-1:0]           ry;
  logic [RW-1:0]           dext;
  logic [COORD_BITS-1:0]   mx;
  logic [COORD_BITS-1:0]   my;

  assign rx_sum = {1'b0, prod_x} + (PROD_W+1)'(1 << (ROUND_SHIFT - 1));
  assign ry_sum = {1'b0, prod_y} + (PROD_W+1)'(1 << (ROUND_SHIFT - 1));
  assign rx     = rx_sum[PROD_W:ROUND_SHIFT];
  assign ry     = ry_sum[PROD_W:ROUND_SHIFT];
  assign dext   = RW'(distm);
  assign mx     = (rx > dext) ? COORD_BITS'(distm) : rx[COORD_BITS-1:0];
  assign my     = (ry > dext) ? COORD_BITS'(distm) : ry[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      point.valid <= 1'b0;
    end else if (adv) begin
      point.valid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      point.point_x         <= neg_x ? -signed'(mx) : signed'(mx);
      point.point_y         <= neg_y ? -signed'(my) : signed'(my);
      point.point_intensity <= intenm;
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Testbench for laser_scan_polar_to_cartesian_top.
// Beam items are driven with random bursts and gaps. Point items are taken
// with a stall pattern that changes from phase to phase. A scoreboard watches
// both channels and the config channel. For every accepted beam it works out
// the point the block should give, if any, and checks each point item against
// the oldest prediction.
// The run has three parts. First, beams under the reset config. Second, a
// short directed set covering angle quadrants, wrap, window edges, an empty
// window and intensity pass/zero. Third, random scan sweeps with some noise
// mixed in, over many config phases.

module tb;
  import lspc_pkg::*;

  localparam int PIPE_LATENCY    = 35;       // acceptance to point
  localparam int CYCLE_LIMIT     = 600000;   // well past the slowest legal run
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 128;      // beams per random phase, about 1550 in all
  localparam int MAX_REPORTS     = 10;

  // atan(2^-i) in binary angle units, rounded down (own copy, not the package's)
  localparam longint BAM_ATAN [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
    64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051,
    64'h00000028, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
  };
  localparam longint GAIN_INV_Q30 = 64'sd652032874;
  localparam longint BAM_HALF     = 64'sd2147483648;
  localparam longint BAM_QUARTER  = 64'sd1073741824;
  localparam longint BAM_TURN     = 64'sd4294967296;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [INTEN_BITS-1:0]        inten;
  } point_t;

  logic clk = 1'b0;
  logic rst;

  lspc_beam_if  beam_ch ();
  lspc_point_if point_ch ();
  lspc_cfg_if   cfg_ch ();

  laser_scan_polar_to_cartesian_top u_dut (
    .clk   (clk),
    .rst   (rst),
    .beam  (beam_ch),
    .point (point_ch),
    .cfg   (cfg_ch)
  );

  always #10 clk = ~clk;

  // Scoreboard's copy of the registers, tracked from accepted config writes
  logic [ANGLE_BITS-1:0]    scan_start;
  logic [ANGLE_BITS-1:0]    scan_step;
  logic [DISTANCE_BITS-1:0] near_limit;
  logic [DISTANCE_BITS-1:0] far_limit;
  logic                     keep_intensity;

  point_t pending_points [$];    // predicted points not yet seen on the output
  int     mismatches = 0;
  int     cycle_count = 0;

  // Sender and receiver idling controls, set per phase
  int gap_mode   = 0;    // 0: back-to-back, 1: short gaps, 2: long gaps
  int stall_mode = 0;    // 0: always ready, 1: light, 2: heavy, 3: fixed pattern
  int burst_left = 0;

  // round(|k| * d / 2^30), half away from zero, clamped to d, then signed as k
  function automatic logic [COORD_BITS-1:0] scale_coord(input longint k,
                                                        input logic [DISTANCE_BITS-1:0] d);
    longint mag;
    longint r;
    mag = (k < 0) ? -k : k;
    r = (mag * longint'(d) + 64'sd536870912) >>> 30;
    if (r > longint'(d)) r = longint'(d);
    if (k < 0) r = -r;
    return r[COORD_BITS-1:0];
  endfunction

  // Point for one beam under the current register copy; returns 0 for a dropped beam.
  // MAX_BEAMS equals 2^INDEX_BITS, so the index can never be out of range.
  function automatic bit project_beam(input logic [INDEX_BITS-1:0] idx,
                                      input logic echo,
                                      input logic [DISTANCE_BITS-1:0] d,
                                      input logic [INTEN_BITS-1:0] inten,
                                      output point_t p);
    logic [ANGLE_BITS-1:0] angle;
    longint z, x, y, nx;
    bit flip;
    p = '0;
    if (!echo || d < near_limit || d > far_limit) return 0;
    angle = scan_start + {{(ANGLE_BITS-INDEX_BITS){1'b0}}, idx} * scan_step;
    // fold into [-quarter, quarter]; a half-turn fold negates cos and sin
    z = longint'(angle);
    if (z >= BAM_HALF) z -= BAM_TURN;
    flip = 1'b0;
    if (z > BAM_QUARTER) begin
      z -= BAM_HALF;
      flip = 1'b1;
    end else if (z < -BAM_QUARTER) begin
      z += BAM_HALF;
      flip = 1'b1;
    end
    x = GAIN_INV_Q30;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  -= BAM_ATAN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  += BAM_ATAN[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    p.x     = scale_coord(x, d);
    p.y     = scale_coord(y, d);
    p.inten = keep_intensity ? inten : '0;
    return 1;
  endfunction

  // Scoreboard: config tracking, output checking and prediction, all at the edge
  always @(posedge clk) begin : scoreboard
    point_t want;
    point_t got;
    point_t pred;
    if (rst) begin
      scan_start     <= '0;
      scan_step      <= '0;
      near_limit     <= '0;
      far_limit      <= '1;
      keep_intensity <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          CFG_START_ANGLE:       scan_start     <= cfg_ch.data;
          CFG_ANGLE_STEP:        scan_step      <= cfg_ch.data;
          CFG_MIN_DISTANCE:      near_limit     <= cfg_ch.data[DISTANCE_BITS-1:0];
          CFG_MAX_DISTANCE:      far_limit      <= cfg_ch.data[DISTANCE_BITS-1:0];
          CFG_INTENSITY_PRESENT: keep_intensity <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (point_ch.valid && point_ch.ready) begin
        got.x     = point_ch.point_x;
        got.y     = point_ch.point_y;
        got.inten = point_ch.point_intensity;
        if (pending_points.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: point item with none predicted: x %0d y %0d inten %0d",
                     $realtime, got.x, got.y, got.inten);
        end else begin
          want = pending_points.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.inten !== want.inten) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: point mismatch: x %0d/%0d y %0d/%0d inten %0d/%0d (exp/act)",
                       $realtime, want.x, got.x, want.y, got.y, want.inten, got.inten);
          end
        end
      end
      // config and beams are never live together, so the register copy is settled here
      if (beam_ch.valid && beam_ch.ready) begin
        if (project_beam(beam_ch.beam_index, beam_ch.echo_valid, beam_ch.distance,
                         beam_ch.beam_intensity, pred)) begin
          pending_points = {pending_points, pred};
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Point receiver: ready pattern depends on stall_mode
  initial begin : point_receiver
    int hold;
    hold = 0;
    point_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      case (stall_mode)
        0: point_ch.ready <= 1'b1;
        3: point_ch.ready <= !((cycle_count % 7 == 0) || (cycle_count % 7 == 3));
        default: begin
          if (hold > 0) begin
            point_ch.ready <= 1'b0;
            hold--;
          end else begin
            point_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < (stall_mode == 1 ? 20 : 45))
              hold = $urandom_range(1, stall_mode == 1 ? 3 : 12);
          end
        end
      endcase
    end
  end

  // One beam item; valid stays high into the next call unless a gap falls between
  task automatic send_beam(input logic [INDEX_BITS-1:0] idx, input logic echo,
                           input logic [DISTANCE_BITS-1:0] d,
                           input logic [INTEN_BITS-1:0] inten);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_mode != 0) begin
        gap = $urandom_range(1, gap_mode == 1 ? 3 : 10);
        beam_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    beam_ch.valid          <= 1'b1;
    beam_ch.beam_index     <= idx;
    beam_ch.echo_valid     <= echo;
    beam_ch.distance       <= d;
    beam_ch.beam_intensity <= inten;
    @(posedge clk);
    while (!beam_ch.ready) @(posedge clk);
  endtask

  // Stop sending, let every predicted point out, then cover dropped beams still in the pipe
  task automatic settle_pipe();
    beam_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 5) @(posedge clk);
  endtask

  // Writes all five registers back-to-back; only called with the pipe empty
  task automatic program_scan(input logic [31:0] start, input logic [31:0] step,
                              input logic [DISTANCE_BITS-1:0] lo,
                              input logic [DISTANCE_BITS-1:0] hi, input logic inten_on);
    cfg_reg_t              regs [5];
    logic [CFG_DATA_BITS-1:0] vals [5];
    regs = '{CFG_START_ANGLE, CFG_ANGLE_STEP, CFG_MIN_DISTANCE, CFG_MAX_DISTANCE,
             CFG_INTENSITY_PRESENT};
    vals = '{start, step, {12'd0, lo}, {12'd0, hi}, {31'd0, inten_on}};
    for (int i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data  <= vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Reset config: angle zero everywhere, full window, intensity zeroed
  task automatic test_reset_config();
    send_beam(12'd0,   1'b1, 20'd0,       16'hFFFF);   // zero distance
    send_beam(12'hFFF, 1'b1, 20'hFFFFF,   16'hFFFF);   // top index, top distance
    send_beam(12'd5,   1'b0, 20'd1234,    16'h0055);   // no echo
    send_beam(12'hAAA, 1'b1, 20'h55555,   16'hAAAA);
    settle_pipe();
  endtask

  // Quadrants, angle wrap, window edges, empty and single-point windows, intensity
  task automatic test_directed();
    // quarter-turn steps: 90, 180, 270 and 360 degrees
    program_scan(32'h4000_0000, 32'h4000_0000, 20'h00100, 20'h80000, 1'b1);
    send_beam(12'd0, 1'b1, 20'h00100, 16'hFFFF);   // at the lower edge
    send_beam(12'd1, 1'b1, 20'h80000, 16'h0000);   // at the upper edge
    send_beam(12'd2, 1'b1, 20'h000FF, 16'h5A5A);   // just below the window
    send_beam(12'd3, 1'b1, 20'h80001, 16'hA5A5);   // just above the window
    send_beam(12'd2, 1'b1, 20'h40000, 16'h1234);
    send_beam(12'd3, 1'b1, 20'h7FFFF, 16'hFEDC);
    send_beam(12'd1, 1'b0, 20'h40000, 16'h00FF);
    send_beam(12'd0, 1'b1, 20'h12345, 16'h8001);
    settle_pipe();
    // start and step at the positive limit, so the angle wraps
    program_scan(32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'd0, 20'hFFFFF, 1'b0);
    send_beam(12'hFFF, 1'b1, 20'hFFFFF, 16'hFFFF);
    send_beam(12'd1,   1'b1, 20'h3C3C3, 16'h0F0F);
    send_beam(12'd2,   1'b1, 20'hC3C3C, 16'hF0F0);
    settle_pipe();
    // empty window: min above max drops everything
    program_scan(32'h8000_0000, 32'h8000_0000, 20'h80001, 20'h80000, 1'b1);
    send_beam(12'd1, 1'b1, 20'h80000, 16'h1111);
    send_beam(12'd2, 1'b1, 20'h80001, 16'h2222);
    settle_pipe();
    // single-point window at the top
    program_scan(32'h0000_0000, 32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF, 1'b1);
    send_beam(12'd7, 1'b1, 20'hFFFFF, 16'h3333);
    send_beam(12'd8, 1'b1, 20'hFFFFE, 16'h4444);
    settle_pipe();
    // single-point window at zero
    program_scan(32'h8000_0000, 32'h8000_0001, 20'd0, 20'd0, 1'b1);
    send_beam(12'd9,  1'b1, 20'd0, 16'h5555);
    send_beam(12'd10, 1'b1, 20'd1, 16'h6666);
    settle_pipe();
  endtask

  // Random phases: a fresh config and idling mix each time, mostly scan sweeps
  task automatic test_random_scans();
    logic [31:0]              start, step;
    logic [DISTANCE_BITS-1:0] lo, hi;
    logic [INDEX_BITS-1:0]    first;
    int                       sent, len, pick;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0: start = 32'h0000_0000;
        1: start = 32'h8000_0000;
        2: start = 32'h7FFF_FFFF;
        default: start = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0: step = 32'h0000_0000;
        1: step = 32'h8000_0000;
        2: step = 32'h7FFF_FFFF;
        3: step = $urandom;
        default: begin
          // a plausible scanner: a few hundred to a few thousand beams per turn
          step = $urandom_range(32'h0010_0000, 32'h0100_0000);
          if ($urandom_range(0, 1)) step = -step;
        end
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        lo = 20'd0;
        hi = 20'hFFFFF;
      end else if (pick < 8) begin
        lo = DISTANCE_BITS'($urandom_range(0, 20'h7FFFF));
        hi = DISTANCE_BITS'($urandom_range(lo, 20'hFFFFF));
      end else if (pick == 8) begin
        lo = DISTANCE_BITS'($urandom);
        hi = lo;
      end else begin
        lo = DISTANCE_BITS'($urandom_range(1, 20'hFFFFF));
        hi = lo - 1'b1;
      end
      program_scan(start, step, lo, hi, 1'($urandom_range(0, 1)));
      // first phase runs flat out, the rest mix gaps and stalls
      gap_mode   = (ph == 0) ? 0 : $urandom_range(0, 2);
      stall_mode = (ph == 0) ? 0 : $urandom_range(0, 3);
      sent       = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 85) begin
          first = ($urandom_range(0, 3) == 0) ? '0 : INDEX_BITS'($urandom);
          len   = $urandom_range(1, 64);
          for (int k = 0; k < len && sent < ITEMS_PER_PHASE; k++) begin
            send_beam(first + INDEX_BITS'(k), $urandom_range(0, 9) != 0,
                      ($urandom_range(0, 9) != 0) ? DISTANCE_BITS'($urandom_range(lo, hi))
                                                  : DISTANCE_BITS'($urandom),
                      INTEN_BITS'($urandom));
            sent++;
          end
        end else begin
          // noise item, every field fully random
          send_beam(INDEX_BITS'($urandom), 1'($urandom_range(0, 1)), DISTANCE_BITS'($urandom),
                    INTEN_BITS'($urandom));
          sent++;
        end
      end
      settle_pipe();
    end
  endtask

  initial begin
    rst                    <= 1'b1;
    beam_ch.valid          <= 1'b0;
    beam_ch.beam_index     <= '0;
    beam_ch.echo_valid     <= 1'b0;
    beam_ch.distance       <= '0;
    beam_ch.beam_intensity <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= CFG_START_ANGLE;
    cfg_ch.data            <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_config();
    test_directed();
    test_random_scans();

    // settle_pipe above has drained every point and waited out the pipe
    if (mismatches == 0 && pending_points.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
